// File: rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 4;
    localparam int MAX_OUT = 32;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_PUSH_FRONT = 4'd0;
    localparam t_op OP_PUSH_BACK  = 4'd1;
    localparam t_op OP_POP_FRONT  = 4'd2;
    localparam t_op OP_POP_BACK   = 4'd3;
    localparam t_op OP_CLEAR      = 4'd4;
    localparam t_op OP_REMOVE     = 4'd5;
    localparam t_op OP_READ_ALL   = 4'd6;
    localparam t_op OP_READ_FIRST = 4'd7;
    localparam t_op OP_READ_LAST  = 4'd8;

    typedef enum logic [1:0] {
        ST_ENTRY = 2'd0,
        ST_DONE  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

// File: rtl/bounded_deque_with_remove_top.sv
// Push, pop, clear and unknown commands: one status item, registered, in the cycle after accept.
// Reads: each entry returned takes a store read, then the output register, up to 32 entries.
// Remove: each held entry is read, then compared and written back; a status item follows.
// The next command is taken once the previous one has handed over its final item.
// Reset clears head and fill count; the entry store is not cleared and needs no clearing pass.
module bounded_deque_with_remove_top #(
    parameter int DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [bdq_pkg::OP_W-1:0]          i_op,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_argument,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [bdq_pkg::DATA_W-1:0] o_item_value,
    output logic [1:0]                        o_status,
    output logic                              o_last_of_run
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = $clog2(bdq_pkg::MAX_OUT + 1);
    localparam int DW = bdq_pkg::DATA_W;
    localparam logic [IW:0]   DEPTH_S = (IW+1)'(DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);
    localparam logic [31:0]   MAX_32  = 32'(bdq_pkg::MAX_OUT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_ADDR,
        S_RD_DATA,
        S_RM_ADDR,
        S_RM_DATA,
        S_RM_END
    } t_state;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_mem_q;

    t_state            r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_off, n_off;
    logic [FW-1:0]     r_kept, n_kept;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DW-1:0]     r_arg, n_arg;
    logic              r_o_valid, n_o_valid;
    logic [DW-1:0]     r_o_value, n_o_value;
    bdq_pkg::t_status  r_o_status, n_o_status;
    logic              r_o_last, n_o_last;

    logic              mem_re, mem_we;
    logic [IW-1:0]     rd_addr, wr_addr;
    logic [DW-1:0]     wr_data;

    logic              out_free, in_acc;
    logic [31:0]       fill32, req, clip1, clip2, start32;
    logic [CW-1:0]     count;

    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] h, input logic [IW-1:0] off);
        logic [IW:0] s;
        s = {1'b0, h} + {1'b0, off};
        if (s >= DEPTH_S) s = s - DEPTH_S;
        return s[IW-1:0];
    endfunction

    assign out_free   = !r_o_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    // read count: min(N, fill, MAX_OUT), negative N as zero, N = MAX_OUT for read-all
    always_comb begin
        fill32 = 32'(r_fill);
        if (i_op == bdq_pkg::OP_READ_ALL) begin
            req = MAX_32;
        end else if (i_argument[DW-1]) begin
            req = 32'd0;
        end else begin
            req = 32'(i_argument);
        end
        clip1   = (req > fill32) ? fill32 : req;
        clip2   = (clip1 > MAX_32) ? MAX_32 : clip1;
        count   = clip2[CW-1:0];
        start32 = (i_op == bdq_pkg::OP_READ_LAST) ? (fill32 - clip2) : 32'd0;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fill     = r_fill;
        n_off      = r_off;
        n_kept     = r_kept;
        n_cnt      = r_cnt;
        n_arg      = r_arg;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_value  = r_o_value;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = f_slot(r_head, r_off[IW-1:0]);
        wr_addr    = f_slot(r_head, r_kept[IW-1:0]);
        wr_data    = r_mem_q;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // status item by default; reads and remove override below
                    n_o_valid  = 1'b1;
                    n_o_value  = '0;
                    n_o_status = bdq_pkg::ST_DONE;
                    n_o_last   = 1'b1;
                    case (i_op)
                        bdq_pkg::OP_PUSH_FRONT: begin
                            if (r_fill == DEPTH_F) begin
                                n_o_status = bdq_pkg::ST_FULL;
                            end else begin
                                n_head  = (r_head == '0) ? IW'(DEPTH - 1) : r_head - IW'(1);
                                mem_we  = 1'b1;
                                wr_addr = n_head;
                                wr_data = i_argument;
                                n_fill  = r_fill + FW'(1);
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK: begin
                            if (r_fill == DEPTH_F) begin
                                n_o_status = bdq_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                wr_addr = f_slot(r_head, r_fill[IW-1:0]);
                                wr_data = i_argument;
                                n_fill  = r_fill + FW'(1);
                            end
                        end
                        bdq_pkg::OP_POP_FRONT: begin
                            if (r_fill == '0) begin
                                n_o_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_head = f_slot(r_head, IW'(1));
                                n_fill = r_fill - FW'(1);
                            end
                        end
                        bdq_pkg::OP_POP_BACK: begin
                            if (r_fill == '0) begin
                                n_o_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_fill = r_fill - FW'(1);
                            end
                        end
                        bdq_pkg::OP_CLEAR: begin
                            n_fill = '0;
                            n_head = '0;
                        end
                        bdq_pkg::OP_REMOVE: begin
                            if (r_fill != '0) begin
                                n_o_valid = 1'b0;
                                n_arg     = i_argument;
                                n_off     = '0;
                                n_kept    = '0;
                                n_state   = S_RM_ADDR;
                            end
                        end
                        bdq_pkg::OP_READ_ALL,
                        bdq_pkg::OP_READ_FIRST,
                        bdq_pkg::OP_READ_LAST: begin
                            if (count == '0) begin
                                n_o_status = (r_fill == '0) ? bdq_pkg::ST_EMPTY
                                                            : bdq_pkg::ST_DONE;
                            end else begin
                                n_o_valid = 1'b0;
                                n_off     = start32[FW-1:0];
                                n_cnt     = count;
                                n_state   = S_RD_ADDR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_ADDR: begin
                mem_re  = 1'b1;
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_value  = r_mem_q;
                    n_o_status = bdq_pkg::ST_ENTRY;
                    n_o_last   = (r_cnt == CW'(1));
                    n_cnt      = r_cnt - CW'(1);
                    n_off      = r_off + FW'(1);
                    n_state    = (r_cnt == CW'(1)) ? S_IDLE : S_RD_ADDR;
                end
            end
            S_RM_ADDR: begin
                mem_re  = 1'b1;
                n_state = S_RM_DATA;
            end
            S_RM_DATA: begin
                // kept never passes the read offset, so the write-back cannot hit
                // an entry still to be read
                if (r_mem_q != r_arg) begin
                    mem_we = 1'b1;
                    n_kept = r_kept + FW'(1);
                end
                n_off   = r_off + FW'(1);
                n_state = (n_off == r_fill) ? S_RM_END : S_RM_ADDR;
            end
            S_RM_END: begin
                if (out_free) begin
                    n_fill     = r_kept;
                    n_o_valid  = 1'b1;
                    n_o_value  = '0;
                    n_o_status = bdq_pkg::ST_DONE;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[wr_addr] <= wr_data;
        if (mem_re) r_mem_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_fill    <= n_fill;
            r_o_valid <= n_o_valid;
        end
        r_off      <= n_off;
        r_kept     <= n_kept;
        r_cnt      <= n_cnt;
        r_arg      <= n_arg;
        r_o_value  <= n_o_value;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid   = r_o_valid;
    assign o_item_value  = r_o_value;
    assign o_status      = r_o_status;
    assign o_last_of_run = r_o_last;

endmodule

// File: verif/deque_scoreboard.sv
module deque_scoreboard
    import bdq_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  t_op                      i_op,
    input  logic signed [DATA_W-1:0] i_argument,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [DATA_W-1:0] i_item_value,
    input  logic [1:0]               i_status,
    input  logic                     i_last_of_run,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int MAX_REPORTS = 50;

    typedef struct {
        logic [DATA_W-1:0] value;
        t_status           status;
        logic              last;
    } t_result;

    t_result           results_due[$];
    logic [DATA_W-1:0] ring [DEPTH];
    int                head;
    int                fill;
    int                errors = 0;

    task automatic report(input string msg);
        if (errors < MAX_REPORTS) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic owe(input logic [DATA_W-1:0] value, input t_status status, input logic last);
        t_result r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        results_due.push_back(r);
    endtask

    // entries from offset first (front = 0), or one status item when count is zero
    task automatic owe_run(input int first, input int count);
        if (count == 0) begin
            if (fill == 0) begin
                owe('0, ST_EMPTY, 1'b1);
            end else begin
                owe('0, ST_DONE, 1'b1);
            end
        end else begin
            for (int i = 0; i < count; i++) begin
                owe(ring[(head + first + i) % DEPTH], ST_ENTRY, i == count - 1);
            end
        end
    endtask

    task automatic apply_command(input t_op cmd, input logic signed [DATA_W-1:0] arg);
        int                n;
        int                kept;
        logic [DATA_W-1:0] word;
        // negative counts read nothing; clip to fill and to the output limit
        n = (arg < 0) ? 0 : int'(arg);
        if (n > fill) n = fill;
        if (n > MAX_OUT) n = MAX_OUT;
        case (cmd)
            OP_PUSH_FRONT: begin
                if (fill >= DEPTH) begin
                    owe('0, ST_FULL, 1'b1);
                end else begin
                    head = (head + DEPTH - 1) % DEPTH;
                    ring[head] = arg;
                    fill++;
                    owe('0, ST_DONE, 1'b1);
                end
            end
            OP_PUSH_BACK: begin
                if (fill >= DEPTH) begin
                    owe('0, ST_FULL, 1'b1);
                end else begin
                    ring[(head + fill) % DEPTH] = arg;
                    fill++;
                    owe('0, ST_DONE, 1'b1);
                end
            end
            OP_POP_FRONT: begin
                if (fill == 0) begin
                    owe('0, ST_EMPTY, 1'b1);
                end else begin
                    head = (head + 1) % DEPTH;
                    fill--;
                    owe('0, ST_DONE, 1'b1);
                end
            end
            OP_POP_BACK: begin
                if (fill == 0) begin
                    owe('0, ST_EMPTY, 1'b1);
                end else begin
                    fill--;
                    owe('0, ST_DONE, 1'b1);
                end
            end
            OP_CLEAR: begin
                fill = 0;
                head = 0;
                owe('0, ST_DONE, 1'b1);
            end
            OP_REMOVE: begin
                // compact in place, order kept
                kept = 0;
                for (int i = 0; i < fill; i++) begin
                    word = ring[(head + i) % DEPTH];
                    if (word != arg) begin
                        ring[(head + kept) % DEPTH] = word;
                        kept++;
                    end
                end
                fill = kept;
                owe('0, ST_DONE, 1'b1);
            end
            OP_READ_ALL:   owe_run(0, (fill > MAX_OUT) ? MAX_OUT : fill);
            OP_READ_FIRST: owe_run(0, n);
            OP_READ_LAST:  owe_run(fill - n, n);
            default:       owe('0, ST_DONE, 1'b1);
        endcase
    endtask

    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            report($sformatf("unexpected item: value %0d status %0d last %0b",
                             i_item_value, i_status, i_last_of_run));
            return;
        end
        want = results_due.pop_front();
        if (i_item_value !== want.value) begin
            report($sformatf("item_value %0d, want %0d", i_item_value, $signed(want.value)));
        end
        if (i_status !== want.status) begin
            report($sformatf("status %0d, want %0d", i_status, want.status));
        end
        if (i_last_of_run !== want.last) begin
            report($sformatf("last_of_run %0b, want %0b", i_last_of_run, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head = 0;
            fill = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_in_valid && !i_in_stall) apply_command(i_op, i_argument);
        end
        o_fail_count <= errors;
        o_pending    <= results_due.size();
    end

endmodule

// File: verif/tb_top.sv
module tb_top;

    import bdq_pkg::*;

    localparam int  DEPTH          = 32;
    localparam int  RESET_CYCLES   = 8;
    localparam int  RANDOM_ITEMS   = 95;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  DRAIN_CYCLES   = 100;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  HOLD_AFTER     = 80;
    localparam t_op OP_UNKNOWN_LO  = OP_READ_LAST + 1;
    localparam t_op OP_UNKNOWN_HI  = '1;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_op                      i_op = OP_CLEAR;
    logic signed [DATA_W-1:0] i_argument = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_item_value;
    logic [1:0]               o_status;
    logic                     o_last_of_run;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int sent_count = 0;
    int taken_count = 0;

    always #5 i_clk = ~i_clk;

    bounded_deque_with_remove_top #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_argument   (i_argument),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_item_value (o_item_value),
        .o_status     (o_status),
        .o_last_of_run(o_last_of_run)
    );

    deque_scoreboard #(
        .DEPTH(DEPTH)
    ) u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_argument   (i_argument),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_item_value (o_item_value),
        .i_status     (o_status),
        .i_last_of_run(o_last_of_run),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** bounded_deque_with_remove_top: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_cmd(input t_op cmd, input logic [DATA_W-1:0] arg);
        int gap;
        gap = ((sent_count / 16) % 3 == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= cmd;
        i_argument <= arg;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        // small values repeat often, so removal finds matches
        if ($urandom_range(0, 2) == 0) return $urandom;
        return $urandom_range(0, 6) - 3;
    endfunction

    function automatic logic [DATA_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom_range(1, 8);
            2:       return $urandom_range(9, 40);
            3:       return $urandom_range(41, 32'h7fff_ffff);
            4:       return $urandom | 32'h8000_0000;
            default: return $urandom_range(1, 33);
        endcase
    endfunction

    // receiver: random stalls per item, quiet stretches, and one long hold-off
    initial begin : receiver
        int  gap;
        bit  held;
        held = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!held && taken_count >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else begin
                gap = ((taken_count / 20) % 3 == 1) ? 0 : $urandom_range(0, 14);
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken_count++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int push_pct;
        int pick;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list cases first
        send_cmd(OP_READ_ALL, '0);
        send_cmd(OP_POP_FRONT, '0);
        send_cmd(OP_POP_BACK, '0);
        send_cmd(OP_READ_FIRST, 32'd5);
        send_cmd(OP_READ_LAST, '0);
        send_cmd(OP_REMOVE, '0);
        send_cmd(OP_PUSH_BACK, 32'h7fff_ffff);
        send_cmd(OP_PUSH_FRONT, 32'h8000_0000);
        send_cmd(OP_PUSH_BACK, 32'hffff_ffff);
        send_cmd(OP_PUSH_FRONT, '0);
        send_cmd(OP_PUSH_BACK, 32'h8000_0000);
        send_cmd(OP_READ_ALL, '0);
        send_cmd(OP_READ_FIRST, '0);
        send_cmd(OP_READ_FIRST, 32'hffff_ffff);
        send_cmd(OP_READ_FIRST, 32'd2);
        send_cmd(OP_READ_LAST, 32'd1);
        send_cmd(OP_READ_LAST, '0);
        send_cmd(OP_READ_LAST, 32'h7fff_ffff);
        send_cmd(OP_REMOVE, 32'h8000_0000);
        send_cmd(OP_READ_ALL, '0);
        send_cmd(OP_POP_FRONT, '0);
        send_cmd(OP_POP_BACK, '0);
        // one entry left: popping it empties the list
        send_cmd(OP_POP_FRONT, '0);
        send_cmd(OP_UNKNOWN_LO, 32'h5a5a_a5a5);
        send_cmd(OP_UNKNOWN_HI, '0);

        // random: fill towards full, then mixed, then mostly draining
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            push_pct = (k < 45) ? 90 : ((k < 80) ? 45 : 20);
            if ($urandom_range(0, 99) < push_pct) begin
                send_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 3) begin
                    send_cmd(OP_POP_FRONT, pick_value());
                end else if (pick < 6) begin
                    send_cmd(OP_POP_BACK, pick_value());
                end else if (pick < 8) begin
                    send_cmd(OP_READ_ALL, pick_value());
                end else if (pick < 11) begin
                    send_cmd(OP_READ_FIRST, pick_count());
                end else if (pick < 14) begin
                    send_cmd(OP_READ_LAST, pick_count());
                end else if (pick < 17) begin
                    send_cmd(OP_REMOVE, pick_value());
                end else if (pick < 18) begin
                    send_cmd(OP_CLEAR, pick_value());
                end else begin
                    send_cmd(t_op'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI)), pick_value());
                end
            end
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** bounded_deque_with_remove_top: PASSED **");
        end else begin
            $display("** bounded_deque_with_remove_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/bdq_pkg.sv
rtl/bounded_deque_with_remove_top.sv
verif/deque_scoreboard.sv
verif/tb_top.sv
